// File: rtl/core/rhh_pkg.sv
// Shared types and constants for the robin-hood hash table.
// Holds the request and response payload structs and the command codes.
// No dependencies.
`timescale 1ns / 1ps

package rhh_pkg;

   localparam int unsigned SLOTS_DEFAULT = 256;
   localparam logic [3:0] SLOTS_LOG2_RESET = 4'd8;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [63:0] key;
      logic [7:0] entry_id;
   } req_type;

   typedef struct packed {
      logic found;
      logic [7:0] match_id;
      logic status;
   } rsp_type;

endpackage

// File: rtl/core/robin_hood_hash_table.sv
// Robin-hood hash table with linear probing over one synchronous slot memory.
// Depends on rhh_pkg for the payload types and command codes.
//
//   channel   signals                       direction  meaning
//   request   start, busy, req_data         in         command, key and id
//   response  rsp_valid, rsp_data           out        one-cycle strobe per command
//   csr       csr_we, csr_wdata             in         slots_log2, write only
//
// An insert or lookup issues the first read from idle and then probes one slot per cycle;
// the slot memory's single read port sets this rate.
// An insert into a full table and an unused command answer in the next cycle, without a probe.
// A clear command sweeps all SLOTS entries of the memory and answers once the last is written.
// After reset the same sweep runs with busy high; csr writes are taken.
// The response is a strobe of one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps

module robin_hood_hash_table #(
   parameter int unsigned SLOTS = rhh_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rhh_pkg::req_type req_data,
   output logic             rsp_valid,
   output rhh_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [3:0]       csr_wdata
);

   import rhh_pkg::*;

   localparam int unsigned ADDR_W = $clog2(SLOTS);
   localparam int unsigned LOG_MAX = $clog2(SLOTS + 1) - 1;
   localparam int unsigned CNT_W = LOG_MAX + 1;
   localparam int unsigned CNT_IW = (LOG_MAX + 1 > 1) ? $clog2(LOG_MAX + 1) : 1;

   typedef struct packed {
      logic valid;
      logic [63:0] key;
      logic [7:0] id;
      logic [ADDR_W-1:0] distance;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] slots_log2_ff;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [63:0] ck_ff, ck_in;
   logic [7:0] cid_ff, cid_in;
   logic [ADDR_W-1:0] cdist_ff, cdist_in;
   logic is_lookup_ff, is_lookup_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic [CNT_W-1:0] cnt_ff [LOG_MAX+1];
   logic [CNT_W-1:0] cnt_in [LOG_MAX+1];

   entry_type mem [SLOTS];
   entry_type rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type wr_data;
   logic place;
   logic cnt_clear;

   logic [4:0] eff;
   logic [CNT_IW-1:0] eff_idx;
   logic [ADDR_W-1:0] mask;
   logic [CNT_W-1:0] size;
   logic full;
   logic [ADDR_W-1:0] home;
   logic [ADDR_W-1:0] next_pos;

   // Table geometry follows the register, capped at the largest power of two that fits.
   always_comb begin
      if ({1'b0, slots_log2_ff} > 5'(LOG_MAX)) begin
         eff = 5'(LOG_MAX);
      end else begin
         eff = {1'b0, slots_log2_ff};
      end
      eff_idx = eff[CNT_IW-1:0];
      for (int i = 0; i < ADDR_W; i++) begin
         mask[i] = (5'(i) < eff);
      end
      for (int i = 0; i < CNT_W; i++) begin
         size[i] = (5'(i) == eff);
      end
   end

   // cnt_ff[k] counts valid entries in slots below two to the k, which gives fullness
   // for any table size without scanning.
   assign full = (cnt_ff[eff_idx] == size);
   assign home = req_data.key[ADDR_W-1:0] & mask;
   assign next_pos = ADDR_W'(pos_ff + 1'b1) & mask;

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      ck_in = ck_ff;
      cid_in = cid_ff;
      cdist_in = cdist_ff;
      is_lookup_in = is_lookup_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      rd_addr = next_pos;
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = '{valid: 1'b1, key: ck_ff, id: cid_ff, distance: cdist_ff};
      place = 1'b0;
      cnt_clear = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = home;
            if (start) begin
               pos_in = home;
               ck_in = req_data.key;
               cid_in = req_data.entry_id;
               cdist_in = '0;
               is_lookup_in = (req_data.cmd == CMD_LOOKUP);
               rsp_in = '0;
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     state_in = ST_CLEAR;
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     cnt_clear = 1'b1;
                  end
                  CMD_INSERT: begin
                     if (full) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = 1'b1;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  CMD_LOOKUP: begin
                     state_in = ST_PROBE;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            pos_in = next_pos;
            if (is_lookup_ff) begin
               cdist_in = cdist_ff + 1'b1;
               priority if (!rd_data_ff.valid) begin
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end else if (rd_data_ff.key == ck_ff) begin
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in.found = 1'b1;
                  rsp_in.match_id = rd_data_ff.id;
               end else if (cdist_ff > rd_data_ff.distance || cdist_ff == mask) begin
                  // Either the key would have displaced this resident, or a full sweep is done.
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_PROBE;
               end
            end else begin
               if (!rd_data_ff.valid) begin
                  wr_en = 1'b1;
                  place = 1'b1;
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end else if (cdist_ff > rd_data_ff.distance) begin
                  // The carried entry takes this slot and the resident moves on.
                  wr_en = 1'b1;
                  ck_in = rd_data_ff.key;
                  cid_in = rd_data_ff.id;
                  cdist_in = rd_data_ff.distance + 1'b1;
               end else begin
                  cdist_in = cdist_ff + 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
            if (clr_cnt_ff == ADDR_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
               rsp_valid_in = clr_rsp_ff;
               rsp_in = '0;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      for (int k = 0; k <= LOG_MAX; k++) begin
         if (cnt_clear) begin
            cnt_in[k] = '0;
         end else if (place && (pos_ff >> k) == '0) begin
            cnt_in[k] = cnt_ff[k] + 1'b1;
         end else begin
            cnt_in[k] = cnt_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         slots_log2_ff <= SLOTS_LOG2_RESET;
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         is_lookup_ff <= 1'b0;
         for (int k = 0; k <= LOG_MAX; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            slots_log2_ff <= csr_wdata;
         end
         clr_cnt_ff <= clr_cnt_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         is_lookup_ff <= is_lookup_in;
         for (int k = 0; k <= LOG_MAX; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
      pos_ff <= pos_in;
      ck_ff <= ck_in;
      cid_ff <= cid_in;
      cdist_ff <= cdist_in;
      rsp_ff <= rsp_in;
   end

   // Read-first slot memory; a command is only taken in idle, so its first read never
   // meets a write to the same slot.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[eff_idx] <= size)
      else $error("occupancy count exceeds table size");

   a_lookup_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && is_lookup_ff) |-> cdist_ff <= mask)
      else $error("lookup probed past one full sweep");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_INSERT && full) |=>
      (rsp_valid && rsp_data.status && !busy))
      else $error("insert into full table not flagged");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither working nor answered");

   a_answer_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.status))
      else $error("response both found and dropped");
`endif

endmodule

// File: bench/robin_hood_hash_table_tb.sv
// Self-checking testbench for the robin-hood hash table.
// Sends commands through start/busy and checks each response strobe against a table model.
// Depends on rhh_pkg and robin_hood_hash_table.
`timescale 1ns / 1ps

module robin_hood_hash_table_tb;
   import rhh_pkg::*;

   localparam int unsigned SLOTS = SLOTS_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_COUNT = 12;
   localparam int unsigned PHASE_ITEMS = 115;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [3:0] csr_wdata = '0;

   robin_hood_hash_table #(.SLOTS(SLOTS)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Table model: occupancy, contents and probe distance of every slot.
   bit table_used [SLOTS];
   logic [63:0] table_key [SLOTS];
   logic [7:0] table_id [SLOTS];
   int unsigned table_dist [SLOTS];
   logic [3:0] table_log2 = SLOTS_LOG2_RESET;

   rsp_type pending_rsp [$];
   logic [63:0] known_keys [$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit idle_enabled = 1'b1;
   logic [3:0] phase_log2 [PHASE_COUNT] = '{4'd3, 4'd4, 4'd2, 4'd8, 4'd5, 4'd0,
                                            4'd1, 4'd6, 4'd15, 4'd7, 4'd9, 4'd3};

   // The slot count saturates at the largest power of two not above SLOTS.
   function automatic int unsigned slots_in_use();
      int unsigned n;
      int unsigned k;
      n = 1;
      for (k = 0; k < table_log2; k++) begin
         if (n * 2 > SLOTS) break;
         n = n * 2;
      end
      return n;
   endfunction

   function automatic logic store_entry(logic [63:0] key, logic [7:0] id);
      int unsigned n, mask, pos, free_slots;
      logic [63:0] held_key, swap_key;
      logic [7:0] held_id, swap_id;
      int unsigned held_dist, swap_dist;
      n = slots_in_use();
      mask = n - 1;
      free_slots = 0;
      for (pos = 0; pos < n; pos++) begin
         if (!table_used[pos]) free_slots++;
      end
      if (free_slots == 0) return 1'b1;
      pos = key[31:0] & mask;
      held_key = key;
      held_id = id;
      held_dist = 0;
      while (table_used[pos]) begin
         // The carried entry takes the slot when it has probed farther.
         if (held_dist > table_dist[pos]) begin
            swap_key = table_key[pos];
            swap_id = table_id[pos];
            swap_dist = table_dist[pos];
            table_key[pos] = held_key;
            table_id[pos] = held_id;
            table_dist[pos] = held_dist;
            held_key = swap_key;
            held_id = swap_id;
            held_dist = swap_dist;
         end
         held_dist++;
         pos = (pos + 1) & mask;
      end
      table_used[pos] = 1'b1;
      table_key[pos] = held_key;
      table_id[pos] = held_id;
      table_dist[pos] = held_dist;
      return 1'b0;
   endfunction

   // Returns the slot holding the key, or -1; gives up after one sweep.
   function automatic int find_slot(logic [63:0] key);
      int unsigned n, mask, pos, steps;
      n = slots_in_use();
      mask = n - 1;
      pos = key[31:0] & mask;
      for (steps = 0; steps < n; steps++) begin
         if (!table_used[pos]) return -1;
         if (table_key[pos] == key) return int'(pos);
         if (steps > table_dist[pos]) return -1;
         pos = (pos + 1) & mask;
      end
      return -1;
   endfunction

   function automatic rsp_type predict_response(req_type item);
      rsp_type r;
      int hit;
      r = '0;
      case (item.cmd)
         CMD_CLEAR: begin
            foreach (table_used[i]) table_used[i] = 1'b0;
         end
         CMD_INSERT: begin
            r.status = store_entry(item.key, item.entry_id);
         end
         CMD_LOOKUP: begin
            hit = find_slot(item.key);
            if (hit >= 0) begin
               r.found = 1'b1;
               r.match_id = table_id[hit];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_rsp.size() == 0) begin
            $error("response strobe with no command outstanding");
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
               mismatches++;
            end
            if (rsp_data.match_id !== want.match_id) begin
               $error("match_id: expected %0d, actual %0d", want.match_id, rsp_data.match_id);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Holds one command on the request port until the transfer completes.
   task automatic send_cmd(input logic [1:0] cmd, input logic [63:0] key, input logic [7:0] id);
      req_type item;
      rsp_type expected;
      item.cmd = cmd;
      item.key = key;
      item.entry_id = id;
      req_data <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected = predict_response(item);
      pending_rsp = {pending_rsp, expected};
      if (cmd == CMD_INSERT) begin
         known_keys = {known_keys, key};
         if (known_keys.size() > 64) void'(known_keys.pop_front());
      end
      if (idle_enabled && $urandom_range(0, 99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_slots_log2(input logic [3:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      table_log2 = value;
   endtask

   task automatic test_basic_ops();
      send_cmd(CMD_LOOKUP, 64'h0, 8'h00);
      send_cmd(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
      send_cmd(CMD_INSERT, 64'h0, 8'h00);
      send_cmd(CMD_INSERT, 64'h5555_AAAA_5555_AA00, 8'hA5);
      send_cmd(CMD_LOOKUP, 64'h5555_AAAA_5555_AA00, 8'h00);
      send_cmd(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
      send_cmd(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
      // A second copy of a key lands behind the first, so lookups keep the old id.
      send_cmd(CMD_INSERT, 64'h0, 8'h3C);
      send_cmd(CMD_LOOKUP, 64'h0, 8'h00);
      send_cmd(CMD_CLEAR, 64'h0, 8'h00);
      send_cmd(CMD_LOOKUP, 64'h5555_AAAA_5555_AA00, 8'h00);
   endtask

   task automatic test_robin_hood_order();
      set_slots_log2(4'd3);
      send_cmd(CMD_INSERT, 64'h1000_0000_0000_0002, 8'h11);
      send_cmd(CMD_INSERT, 64'h2000_0000_0000_0003, 8'h22);
      send_cmd(CMD_INSERT, 64'h3000_0000_0000_0002, 8'h33);
      send_cmd(CMD_INSERT, 64'h4000_0000_0000_0002, 8'h44);
      send_cmd(CMD_LOOKUP, 64'h2000_0000_0000_0003, 8'h00);
      send_cmd(CMD_LOOKUP, 64'h4000_0000_0000_0002, 8'h00);
      send_cmd(CMD_LOOKUP, 64'h5000_0000_0000_0003, 8'h00);
   endtask

   task automatic test_full_and_sweep();
      set_slots_log2(4'd0);
      send_cmd(CMD_CLEAR, 64'h0, 8'h00);
      send_cmd(CMD_INSERT, 64'h0123_4567_89AB_CDEF, 8'h5A);
      send_cmd(CMD_INSERT, 64'hFEDC_BA98_7654_3210, 8'hC3);
      // Every slot in use holds a key, so this lookup runs the whole sweep.
      send_cmd(CMD_LOOKUP, 64'hFEDC_BA98_7654_3210, 8'h00);
      set_slots_log2(4'd1);
      send_cmd(CMD_INSERT, 64'h8000_0000_0000_0001, 8'h7E);
      send_cmd(CMD_INSERT, 64'h8000_0000_0000_0000, 8'h81);
   endtask

   task automatic test_resize();
      // Entries stay in place; they are probed under the new mask.
      set_slots_log2(4'd15);
      send_cmd(CMD_LOOKUP, 64'h8000_0000_0000_0001, 8'h00);
      send_cmd(CMD_INSERT, 64'h0000_0000_0000_00FF, 8'h99);
      set_slots_log2(4'd2);
      send_cmd(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 8'h00);
      set_slots_log2(4'd9);
      send_cmd(CMD_LOOKUP, 64'h0000_0000_0000_00FF, 8'h00);
   endtask

   function automatic logic [63:0] random_key();
      logic [63:0] key;
      key = {$urandom, $urandom};
      // Crowd half the keys into a few home slots so probe chains grow long.
      if ($urandom_range(0, 1) == 0) key[7:0] = 8'($urandom_range(0, 7));
      return key;
   endfunction

   task automatic test_random_traffic();
      int unsigned p, i, pick;
      logic [63:0] key;
      for (p = 0; p < PHASE_COUNT; p++) begin
         set_slots_log2(phase_log2[p]);
         idle_enabled = (p != 3);
         if ($urandom_range(0, 1) == 0) send_cmd(CMD_CLEAR, random_key(), 8'($urandom));
         for (i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               send_cmd(CMD_CLEAR, random_key(), 8'($urandom));
            end else if (pick < 6) begin
               send_cmd(CMD_UNUSED, random_key(), 8'($urandom));
            end else if (pick < 50) begin
               send_cmd(CMD_INSERT, random_key(), 8'($urandom));
            end else begin
               if (known_keys.size() != 0 && $urandom_range(0, 99) < 65) begin
                  key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                  // Same home slot, different key: must not match.
                  if ($urandom_range(0, 7) == 0) key = key ^ (64'd1 << $urandom_range(8, 63));
               end else begin
                  key = random_key();
               end
               send_cmd(CMD_LOOKUP, key, 8'($urandom));
            end
         end
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_robin_hood_order();
      test_full_and_sweep();
      test_resize();
      test_random_traffic();
      drain();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
